// ----- rtl/lspc_pkg.sv -----
// ---------------------------------------------------------------------------
// lspc_pkg
// widths, constants, register indexes and codes for the load shedding
// protection controller
// ---------------------------------------------------------------------------
package lspc_pkg;

   localparam int CODE_W     = 10;
   localparam int GAIN_W     = 16;
   localparam int LEVEL_W    = 10;
   localparam int WATT_W     = 17;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // shared multiplier operands and product
   localparam int MUL_W  = 20;
   localparam int PROD_W = 2 * MUL_W;

   // fixed point scale of the gains
   localparam int SCALE_SHIFT = 16;

   // divide by ten as multiply by ceil(2^23 / 10), exact for products below 2^22
   localparam int                RECIP_SHIFT = 23;
   localparam logic [MUL_W-1:0]  RECIP_TEN   = 20'd838861;

   // register reset values
   localparam logic [GAIN_W-1:0]  VOLTAGE_GAIN_RST    = 16'd16015;
   localparam logic [GAIN_W-1:0]  CURRENT_GAIN_RST    = 16'd1280;
   localparam logic [LEVEL_W-1:0] OVERVOLT_TRIP_RST   = 10'd235;
   localparam logic [LEVEL_W-1:0] OVERVOLT_CLEAR_RST  = 10'd232;
   localparam logic [LEVEL_W-1:0] UNDERVOLT_LEVEL_RST = 10'd222;
   localparam logic [LEVEL_W-1:0] OVERCURRENT_RST     = 10'd14;
   localparam logic [LEVEL_W-1:0] THIRD_ON_RST        = 10'd7;
   localparam logic [LEVEL_W-1:0] THIRD_OFF_RST       = 10'd11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLTAGE_GAIN    = 4'd0,
      CSR_CURRENT_GAIN    = 4'd1,
      CSR_OVERVOLT_TRIP   = 4'd2,
      CSR_OVERVOLT_CLEAR  = 4'd3,
      CSR_UNDERVOLT_LEVEL = 4'd4,
      CSR_OVERCURRENT     = 4'd5,
      CSR_THIRD_ON        = 4'd6,
      CSR_THIRD_OFF       = 4'd7
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL_V  = 6'b000010,
      ST_MUL_C  = 6'b000100,
      ST_MUL_P  = 6'b001000,
      ST_MUL_D  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      VS_NORMAL = 2'd0,
      VS_UNDER  = 2'd1,
      VS_OVER   = 2'd2,
      VS_BAND   = 2'd3
   } vstatus_type;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_AUTO   = 2'd1,
      MODE_MANUAL = 2'd2,
      MODE_HELD   = 2'd3
   } mode_type;

endpackage

// ----- rtl/lspc_if.sv -----
// ---------------------------------------------------------------------------
// lspc channel interfaces
// sample channel and result channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface lspc_req_if
   import lspc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  voltage_code;
   logic [CODE_W-1:0]  current_code;
   logic               auto_switch;
   logic               manual_switch;
   logic               first_load_request;
   logic               second_load_request;
   logic               third_load_enable;

   modport source (
      output valid, voltage_code, current_code, auto_switch, manual_switch,
             first_load_request, second_load_request, third_load_enable,
      input  ready
   );
   modport sink (
      input  valid, voltage_code, current_code, auto_switch, manual_switch,
             first_load_request, second_load_request, third_load_enable,
      output ready
   );
endinterface

interface lspc_rsp_if
   import lspc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  volts;
   logic [CODE_W-1:0]  amps_tenths;
   logic [WATT_W-1:0]  watts;
   logic               fault_flag;
   logic               relay_one;
   logic               relay_two;
   logic               relay_three;
   logic [1:0]         voltage_status;
   logic [1:0]         mode_code;

   modport source (
      output valid, volts, amps_tenths, watts, fault_flag, relay_one, relay_two,
             relay_three, voltage_status, mode_code,
      input  ready
   );
   modport sink (
      input  valid, volts, amps_tenths, watts, fault_flag, relay_one, relay_two,
             relay_three, voltage_status, mode_code,
      output ready
   );
endinterface

// ----- rtl/lspc_mul.sv -----
// ---------------------------------------------------------------------------
// lspc_mul
// shared unsigned multiplier with registered product
// ---------------------------------------------------------------------------
module lspc_mul
   import lspc_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_W-1:0]   op_a,
   input  logic [MUL_W-1:0]   op_b,
   output logic [PROD_W-1:0]  prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/load_shedding_protection_controller_unit.sv -----
// ---------------------------------------------------------------------------
// load_shedding_protection_controller_unit
// scales voltage/current samples, computes power and drives three relays
// ---------------------------------------------------------------------------
// One sample is taken per transfer on req_bus and gives exactly one result
// transfer on rsp_bus. A sample runs through one shared 20x20 multiplier four
// times (voltage scale, current scale, volts times amps, divide by ten as a
// reciprocal multiply), so a sample goes from its transfer to the loaded
// result through four multiplier passes and one decision state. A new
// sample is accepted only in the idle state, so no sample is taken before
// the last one is through. req_bus.ready is high only while the sequencer
// is idle; the result sits in an output register, so the next sample can be
// taken while the previous result still waits. If that result has not been
// taken when the next one is done, the decision state waits for it.
// Configuration registers are written through csr_wr_en / csr_index /
// csr_wr_data; indexes above the last register are ignored.
// Write them only while no sample is in flight.
// ---------------------------------------------------------------------------
module load_shedding_protection_controller_unit
   import lspc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lspc_req_if.sink               req_bus,
   lspc_rsp_if.source             rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   // configuration registers
   logic [GAIN_W-1:0]  voltage_gain_ff;
   logic [GAIN_W-1:0]  current_gain_ff;
   logic [LEVEL_W-1:0] overvolt_trip_ff;
   logic [LEVEL_W-1:0] overvolt_clear_ff;
   logic [LEVEL_W-1:0] undervolt_level_ff;
   logic [LEVEL_W-1:0] overcurrent_ff;
   logic [LEVEL_W-1:0] third_on_ff;
   logic [LEVEL_W-1:0] third_off_ff;

   // controller state
   logic fault_ff,  fault_in;
   logic latch3_ff, latch3_in;
   logic relay1_ff, relay1_in;
   logic relay2_ff, relay2_in;
   logic relay3_ff, relay3_in;

   // sequencer
   state_type state_ff, state_in;

   // captured sample
   logic [CODE_W-1:0] vcode_ff;
   logic [CODE_W-1:0] ccode_ff;
   logic              sw_auto_ff;
   logic              sw_man_ff;
   logic              req1_ff;
   logic              req2_ff;
   logic              en3_ff;

   // scaled values
   logic [CODE_W-1:0] vol_ff;
   logic [CODE_W-1:0] cur_ff;
   logic [MUL_W-1:0]  power_ff;

   // shared multiplier
   logic [MUL_W-1:0]  mul_a;
   logic [MUL_W-1:0]  mul_b;
   logic [PROD_W-1:0] mul_prod;
   logic [CODE_W-1:0] prod_scaled;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_volts_ff;
   logic [CODE_W-1:0]  rsp_amps_ff;
   logic [WATT_W-1:0]  rsp_watts_ff;
   vstatus_type        rsp_status_ff;
   mode_type           rsp_mode_ff;

   // decision outputs
   vstatus_type status_in;
   mode_type    mode_in;
   logic        sample_xfer;
   logic        finish_go;

   assign sample_xfer = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   // result slot free, or being emptied this cycle
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   // (code * gain) >> 16
   assign prod_scaled = mul_prod[SCALE_SHIFT +: CODE_W];

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_gain_ff    <= VOLTAGE_GAIN_RST;
         current_gain_ff    <= CURRENT_GAIN_RST;
         overvolt_trip_ff   <= OVERVOLT_TRIP_RST;
         overvolt_clear_ff  <= OVERVOLT_CLEAR_RST;
         undervolt_level_ff <= UNDERVOLT_LEVEL_RST;
         overcurrent_ff     <= OVERCURRENT_RST;
         third_on_ff        <= THIRD_ON_RST;
         third_off_ff       <= THIRD_OFF_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VOLTAGE_GAIN:    voltage_gain_ff    <= csr_wr_data[GAIN_W-1:0];
            CSR_CURRENT_GAIN:    current_gain_ff    <= csr_wr_data[GAIN_W-1:0];
            CSR_OVERVOLT_TRIP:   overvolt_trip_ff   <= csr_wr_data[LEVEL_W-1:0];
            CSR_OVERVOLT_CLEAR:  overvolt_clear_ff  <= csr_wr_data[LEVEL_W-1:0];
            CSR_UNDERVOLT_LEVEL: undervolt_level_ff <= csr_wr_data[LEVEL_W-1:0];
            CSR_OVERCURRENT:     overcurrent_ff     <= csr_wr_data[LEVEL_W-1:0];
            CSR_THIRD_ON:        third_on_ff        <= csr_wr_data[LEVEL_W-1:0];
            CSR_THIRD_OFF:       third_off_ff       <= csr_wr_data[LEVEL_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // multiplier operand select, one pass per state
   // ------------------------------------------------------------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_V: begin
            // raw voltage times voltage gain
            mul_a = MUL_W'(vcode_ff);
            mul_b = MUL_W'(voltage_gain_ff);
         end
         ST_MUL_C: begin
            // raw current times current gain
            mul_a = MUL_W'(ccode_ff);
            mul_b = MUL_W'(current_gain_ff);
         end
         ST_MUL_P: begin
            // volts times amps, current taken straight from the product
            mul_a = MUL_W'(vol_ff);
            mul_b = MUL_W'(prod_scaled);
         end
         ST_MUL_D: begin
            // power product times reciprocal of ten
            mul_a = mul_prod[MUL_W-1:0];
            mul_b = RECIP_TEN;
         end
         ST_FINISH: begin
            // repeat the divide pass so the product holds while the result waits
            mul_a = power_ff;
            mul_b = RECIP_TEN;
         end
         default: ;
      endcase
   end

   lspc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (sample_xfer) state_in = ST_MUL_V;
         ST_MUL_V:  state_in = ST_MUL_C;
         ST_MUL_C:  state_in = ST_MUL_P;
         ST_MUL_P:  state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_FINISH;
         ST_FINISH: if (finish_go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sample capture and scaled value pickup
   always_ff @(posedge clock) begin
      if (sample_xfer) begin
         vcode_ff   <= req_bus.voltage_code;
         ccode_ff   <= req_bus.current_code;
         sw_auto_ff <= req_bus.auto_switch;
         sw_man_ff  <= req_bus.manual_switch;
         req1_ff    <= req_bus.first_load_request;
         req2_ff    <= req_bus.second_load_request;
         en3_ff     <= req_bus.third_load_enable;
      end
      if (state_ff == ST_MUL_C) begin
         vol_ff <= prod_scaled;
      end
      if (state_ff == ST_MUL_P) begin
         cur_ff <= prod_scaled;
      end
      if (state_ff == ST_MUL_D) begin
         power_ff <= mul_prod[MUL_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // protection and relay decision
   // ------------------------------------------------------------------
   always_comb begin
      fault_in  = fault_ff;
      latch3_in = latch3_ff;
      relay1_in = relay1_ff;
      relay2_in = relay2_ff;
      relay3_in = relay3_ff;

      // over-current sheds the third load
      if (cur_ff > overcurrent_ff) begin
         relay3_in = 1'b0;
      end

      // over-voltage latch with hysteresis, trip sheds everything
      if (vol_ff > overvolt_trip_ff) begin
         fault_in  = 1'b1;
         relay1_in = 1'b0;
         relay2_in = 1'b0;
         relay3_in = 1'b0;
      end else if (vol_ff <= overvolt_clear_ff) begin
         fault_in = 1'b0;
      end

      // status priority: normal, under, over, band
      if (vol_ff > undervolt_level_ff && vol_ff <= overvolt_clear_ff) begin
         status_in = VS_NORMAL;
      end else if (vol_ff <= undervolt_level_ff) begin
         status_in = VS_UNDER;
      end else if (vol_ff > overvolt_trip_ff) begin
         status_in = VS_OVER;
      end else begin
         status_in = VS_BAND;
      end

      // mode handling
      if (!sw_auto_ff && !sw_man_ff) begin
         mode_in   = MODE_OFF;
         relay1_in = 1'b0;
         relay2_in = 1'b0;
         relay3_in = 1'b0;
      end else if (sw_auto_ff && !sw_man_ff && !fault_in) begin
         mode_in   = MODE_AUTO;
         relay1_in = 1'b1;
         relay2_in = 1'b1;
         if (cur_ff <= third_on_ff && !latch3_ff) begin
            relay3_in = 1'b1;
            latch3_in = 1'b1;
         end else if (cur_ff >= third_off_ff && latch3_ff) begin
            relay3_in = 1'b0;
            latch3_in = 1'b0;
         end
      end else if (sw_man_ff && !sw_auto_ff && !fault_in) begin
         mode_in = MODE_MANUAL;
         if (cur_ff <= third_on_ff && !latch3_ff && en3_ff) begin
            relay3_in = 1'b1;
            latch3_in = 1'b1;
         end else if (cur_ff >= third_off_ff && latch3_ff) begin
            relay3_in = 1'b0;
            latch3_in = 1'b0;
         end else if (!en3_ff) begin
            relay3_in = 1'b0;
            latch3_in = 1'b0;
         end
         relay1_in = req1_ff;
         relay2_in = req2_ff;
      end else begin
         // both switches, or fault with one switch: relays held
         mode_in = MODE_HELD;
      end
   end

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fault_ff     <= 1'b0;
         latch3_ff    <= 1'b0;
         relay1_ff    <= 1'b0;
         relay2_ff    <= 1'b0;
         relay3_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish_go) begin
            fault_ff  <= fault_in;
            latch3_ff <= latch3_in;
            relay1_ff <= relay1_in;
            relay2_ff <= relay2_in;
            relay3_ff <= relay3_in;
         end
      end
   end

   // result payload, loaded when the decision commits
   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_volts_ff  <= vol_ff;
         rsp_amps_ff   <= cur_ff;
         rsp_watts_ff  <= mul_prod[RECIP_SHIFT +: WATT_W];
         rsp_status_ff <= status_in;
         rsp_mode_ff   <= mode_in;
      end
   end

   // ------------------------------------------------------------------
   // result channel
   // ------------------------------------------------------------------
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.volts          = rsp_volts_ff;
   assign rsp_bus.amps_tenths    = rsp_amps_ff;
   assign rsp_bus.watts          = rsp_watts_ff;
   // state registers hold the committed values until the next sample commits
   assign rsp_bus.fault_flag     = fault_ff;
   assign rsp_bus.relay_one      = relay1_ff;
   assign rsp_bus.relay_two      = relay2_ff;
   assign rsp_bus.relay_three    = relay3_ff;
   assign rsp_bus.voltage_status = rsp_status_ff;
   assign rsp_bus.mode_code      = rsp_mode_ff;

endmodule

// ----- tb/tb_load_shedding_protection_controller_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_load_shedding_protection_controller_unit
// Self-checking bench for the load shedding controller. A directed table of
// samples runs first, then random samples over a series of register
// settings. Each accepted sample goes through a local model of the scaling,
// fault latch, mode and relay logic, and each result transfer is compared
// field by field, in order, with the model's prediction or the table's fixed reading.
// ---------------------------------------------------------------------------
module tb_load_shedding_protection_controller_unit;
   import lspc_pkg::*;

   localparam int LIMIT_CYCLES     = 400000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_CYCLES     = 16;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int PHASE_COUNT      = 10;
   localparam int SAMPLES_PER_PHASE = 155;
   localparam int DIRECTED_COUNT   = 21;
   localparam int CODE_MAX         = (1 << CODE_W) - 1;

   typedef struct packed {
      logic [CODE_W-1:0] voltage_code;
      logic [CODE_W-1:0] current_code;
      logic              auto_switch;
      logic              manual_switch;
      logic              first_load_request;
      logic              second_load_request;
      logic              third_load_enable;
   } sample_type;

   typedef struct packed {
      logic [CODE_W-1:0] volts;
      logic [CODE_W-1:0] amps_tenths;
      logic [WATT_W-1:0] watts;
      logic              fault_flag;
      logic              relay_one;
      logic              relay_two;
      logic              relay_three;
      vstatus_type       voltage_status;
      mode_type          mode_code;
   } reading_type;

   typedef struct packed {
      sample_type  stim;
      bit          has_fixed;
      reading_type fixed;
   } directed_row_type;

   typedef enum int {
      SET_MAXIMA,
      SET_ZERO,
      SET_DEFAULTS,
      SET_TYPICAL,
      SET_CROSSED
   } setting_kind_type;

   // results that can be read straight off the rules with reset settings
   localparam reading_type RESET_IDLE_READING =
      '{10'd0, 10'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0, VS_UNDER, MODE_OFF};
   localparam reading_type FULL_SCALE_READING =
      '{10'd249, 10'd19, 17'd473, 1'b1, 1'b0, 1'b0, 1'b0, VS_OVER, MODE_HELD};
   localparam reading_type AUTO_RECOVER_READING =
      '{10'd0, 10'd0, 17'd0, 1'b0, 1'b1, 1'b1, 1'b1, VS_UNDER, MODE_AUTO};
   localparam reading_type NO_FIXED_READING =
      '{10'd0, 10'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0, VS_NORMAL, MODE_OFF};

   // volts/tenths noted for the reset gains (16015 and 1280)
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_COUNT] = '{
      // idle after reset, then full scale trips the fault, then recovery
      '{'{10'd0,    10'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, RESET_IDLE_READING},
      '{'{10'd1023, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, FULL_SCALE_READING},
      '{'{10'd0,    10'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, AUTO_RECOVER_READING},
      // auto: 229 V, third load off at 1.2 A, on at 0.5 A, held at 0.9 A
      '{'{10'd941,  10'd615,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_FIXED_READING},
      '{'{10'd941,  10'd256,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_FIXED_READING},
      '{'{10'd941,  10'd461,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_FIXED_READING},
      // hysteresis band with over-current
      '{'{10'd958,  10'd820,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_FIXED_READING},
      // exactly at the trip level, then just above, then back into the band
      '{'{10'd962,  10'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_FIXED_READING},
      '{'{10'd966,  10'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_FIXED_READING},
      '{'{10'd958,  10'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_FIXED_READING},
      // manual at the clear level: enable high, over-current, enable low
      '{'{10'd950,  10'd0,    1'b0, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, NO_FIXED_READING},
      '{'{10'd950,  10'd820,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, NO_FIXED_READING},
      '{'{10'd950,  10'd0,    1'b0, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, NO_FIXED_READING},
      // both switches high keeps relays, both low opens them
      '{'{10'd950,  10'd0,    1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_FIXED_READING},
      '{'{10'd900,  10'd300,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_FIXED_READING},
      '{'{10'd900,  10'd300,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, NO_FIXED_READING},
      // alternating bit patterns
      '{'{10'd682,  10'd341,  1'b0, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, NO_FIXED_READING},
      '{'{10'd341,  10'd682,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_FIXED_READING},
      // fault in manual mode, clear with full-scale current, then the band
      '{'{10'd1023, 10'd0,    1'b0, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_FIXED_READING},
      '{'{10'd0,    10'd1023, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_FIXED_READING},
      '{'{10'd955,  10'd500,  1'b0, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_FIXED_READING}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   lspc_req_if req_bus ();
   lspc_rsp_if rsp_bus ();

   load_shedding_protection_controller_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // model copy of the registers
   logic [GAIN_W-1:0]  voltage_gain_q  = VOLTAGE_GAIN_RST;
   logic [GAIN_W-1:0]  current_gain_q  = CURRENT_GAIN_RST;
   logic [LEVEL_W-1:0] trip_lvl        = OVERVOLT_TRIP_RST;
   logic [LEVEL_W-1:0] clear_lvl       = OVERVOLT_CLEAR_RST;
   logic [LEVEL_W-1:0] under_lvl       = UNDERVOLT_LEVEL_RST;
   logic [LEVEL_W-1:0] overcurrent_lvl = OVERCURRENT_RST;
   logic [LEVEL_W-1:0] third_on_lvl    = THIRD_ON_RST;
   logic [LEVEL_W-1:0] third_off_lvl   = THIRD_OFF_RST;

   // model copy of the latches and relays
   bit fault_on         = 1'b0;
   bit third_load_armed = 1'b0;
   bit relay_one_on     = 1'b0;
   bit relay_two_on     = 1'b0;
   bit relay_three_on   = 1'b0;

   reading_type pending_readings [$];

   int unsigned sender_idle_pct   = 22;
   int unsigned receiver_idle_pct = 79;
   bit          long_hold_armed   = 1'b0;
   bit          long_hold_taken   = 1'b0;
   int          hold_left         = 0;
   bit          run_auto          = 1'b1;
   bit          run_manual        = 1'b0;

   int failures        = 0;
   int samples_sent    = 0;
   int results_checked = 0;
   int faults_seen     = 0;
   int settings_used   = 1;
   int mode_seen [4]   = '{0, 0, 0, 0};
   int cycle_count     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // one step of the controller: scaling, fault latch, status, mode, relays
   function automatic reading_type evaluate_protection(input sample_type s);
      reading_type               r;
      logic [CODE_W+GAIN_W-1:0]  v_scaled;
      logic [CODE_W+GAIN_W-1:0]  c_scaled;
      logic [CODE_W-1:0]         vol;
      logic [CODE_W-1:0]         cur;
      logic [2*CODE_W-1:0]       power_x10;
      v_scaled  = s.voltage_code * voltage_gain_q;
      c_scaled  = s.current_code * current_gain_q;
      vol       = v_scaled[CODE_W+GAIN_W-1:SCALE_SHIFT];
      cur       = c_scaled[CODE_W+GAIN_W-1:SCALE_SHIFT];
      power_x10 = vol * cur;

      if (cur > overcurrent_lvl) relay_three_on = 1'b0;

      if (vol > trip_lvl) begin
         fault_on       = 1'b1;
         relay_one_on   = 1'b0;
         relay_two_on   = 1'b0;
         relay_three_on = 1'b0;
      end else if (vol <= clear_lvl) begin
         fault_on = 1'b0;
      end

      // priority order decides overlapping thresholds
      if (vol > under_lvl && vol <= clear_lvl) r.voltage_status = VS_NORMAL;
      else if (vol <= under_lvl)              r.voltage_status = VS_UNDER;
      else if (vol > trip_lvl)                r.voltage_status = VS_OVER;
      else                                    r.voltage_status = VS_BAND;

      if (!s.auto_switch && !s.manual_switch) begin
         r.mode_code    = MODE_OFF;
         relay_one_on   = 1'b0;
         relay_two_on   = 1'b0;
         relay_three_on = 1'b0;
      end else if (s.auto_switch && !s.manual_switch && !fault_on) begin
         r.mode_code  = MODE_AUTO;
         relay_one_on = 1'b1;
         relay_two_on = 1'b1;
         if (cur <= third_on_lvl && !third_load_armed) begin
            relay_three_on   = 1'b1;
            third_load_armed = 1'b1;
         end else if (cur >= third_off_lvl && third_load_armed) begin
            relay_three_on   = 1'b0;
            third_load_armed = 1'b0;
         end
      end else if (s.manual_switch && !s.auto_switch && !fault_on) begin
         r.mode_code = MODE_MANUAL;
         if (cur <= third_on_lvl && !third_load_armed && s.third_load_enable) begin
            relay_three_on   = 1'b1;
            third_load_armed = 1'b1;
         end else if (cur >= third_off_lvl && third_load_armed) begin
            relay_three_on   = 1'b0;
            third_load_armed = 1'b0;
         end else if (!s.third_load_enable) begin
            relay_three_on   = 1'b0;
            third_load_armed = 1'b0;
         end
         relay_one_on = s.first_load_request;
         relay_two_on = s.second_load_request;
      end else begin
         // both switches, or fault with one switch: relays stay as they are
         r.mode_code = MODE_HELD;
      end

      r.volts       = vol;
      r.amps_tenths = cur;
      r.watts       = WATT_W'(power_x10 / 10);
      r.fault_flag  = fault_on;
      r.relay_one   = relay_one_on;
      r.relay_two   = relay_two_on;
      r.relay_three = relay_three_on;
      return r;
   endfunction

   // smallest raw code that scales to at least the given level
   function automatic logic [CODE_W-1:0] code_for_level(input int level,
                                                       input logic [GAIN_W-1:0] gain);
      longint code;
      if (gain == 0) return CODE_W'($urandom);
      if (level < 0) level = 0;
      code = ((longint'(level) << SCALE_SHIFT) + gain - 1) / gain;
      if (code > CODE_MAX) code = CODE_MAX;
      return CODE_W'(code);
   endfunction

   // mostly samples near the live thresholds, with sticky switch positions
   function automatic sample_type random_sample();
      sample_type s;
      int         pick;
      int         near;
      if ($urandom_range(99, 0) < 15) begin
         pick       = $urandom_range(99, 0);
         run_auto   = (pick < 40) || (pick >= 88);
         run_manual = (pick >= 40 && pick < 75) || (pick >= 88);
      end
      case ($urandom_range(2, 0))
         0:       near = int'(trip_lvl);
         1:       near = int'(clear_lvl);
         default: near = int'(under_lvl);
      endcase
      if ($urandom_range(99, 0) < 60)
         s.voltage_code = code_for_level(near + int'($urandom_range(4, 0)) - 2,
                                         voltage_gain_q);
      else
         s.voltage_code = CODE_W'($urandom);
      case ($urandom_range(2, 0))
         0:       near = int'(overcurrent_lvl);
         1:       near = int'(third_on_lvl);
         default: near = int'(third_off_lvl);
      endcase
      if ($urandom_range(99, 0) < 60)
         s.current_code = code_for_level(near + int'($urandom_range(4, 0)) - 2,
                                         current_gain_q);
      else
         s.current_code = CODE_W'($urandom);
      s.auto_switch         = run_auto;
      s.manual_switch       = run_manual;
      s.first_load_request  = 1'($urandom);
      s.second_load_request = 1'($urandom);
      s.third_load_enable   = ($urandom_range(9, 0) < 7);
      return s;
   endfunction

   // offer one sample, wait for its transfer, then queue its prediction
   task automatic offer_sample(input sample_type s, input bit has_fixed,
                               input reading_type fixed);
      reading_type predicted;
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.voltage_code        <= s.voltage_code;
      req_bus.current_code        <= s.current_code;
      req_bus.auto_switch         <= s.auto_switch;
      req_bus.manual_switch       <= s.manual_switch;
      req_bus.first_load_request  <= s.first_load_request;
      req_bus.second_load_request <= s.second_load_request;
      req_bus.third_load_enable   <= s.third_load_enable;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = evaluate_protection(s);
      pending_readings.push_back(has_fixed ? fixed : predicted);
      samples_sent++;
   endtask

   function automatic bit field_ok(input string name, input int unsigned want,
                                   input int unsigned got);
      if (want != got)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return want == got;
   endfunction

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (long_hold_armed && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            hold_left       = LONG_HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin : check_results
      reading_type got;
      reading_type want;
      bit          bad;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.volts          = rsp_bus.volts;
         got.amps_tenths    = rsp_bus.amps_tenths;
         got.watts          = rsp_bus.watts;
         got.fault_flag     = rsp_bus.fault_flag;
         got.relay_one      = rsp_bus.relay_one;
         got.relay_two      = rsp_bus.relay_two;
         got.relay_three    = rsp_bus.relay_three;
         got.voltage_status = vstatus_type'(rsp_bus.voltage_status);
         got.mode_code      = mode_type'(rsp_bus.mode_code);
         if (pending_readings.size() == 0) begin
            $display("%0t: result transfer with nothing expected, volts %0d",
                     $time, got.volts);
            failures++;
         end else begin
            want = pending_readings.pop_front();
            bad  = !field_ok("volts", want.volts, got.volts)
                 | !field_ok("amps_tenths", want.amps_tenths, got.amps_tenths)
                 | !field_ok("watts", want.watts, got.watts)
                 | !field_ok("fault_flag", want.fault_flag, got.fault_flag)
                 | !field_ok("relay_one", want.relay_one, got.relay_one)
                 | !field_ok("relay_two", want.relay_two, got.relay_two)
                 | !field_ok("relay_three", want.relay_three, got.relay_three)
                 | !field_ok("voltage_status", want.voltage_status, got.voltage_status)
                 | !field_ok("mode_code", want.mode_code, got.mode_code);
            if (bad) failures++;
            results_checked++;
            if (got.fault_flag) faults_seen++;
            mode_seen[int'(got.mode_code)]++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_readings.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      setting_kind_type      kind;
      int                    level [8];
      logic [CSR_IDX_W-1:0]  wr_index;
      logic [CSR_DATA_W-1:0] wr_data;

      reset                       <= 1'b1;
      csr_wr_en                   <= 1'b0;
      csr_index                   <= CSR_VOLTAGE_GAIN;
      csr_wr_data                 <= '0;
      req_bus.valid               <= 1'b0;
      req_bus.voltage_code        <= '0;
      req_bus.current_code        <= '0;
      req_bus.auto_switch         <= 1'b0;
      req_bus.manual_switch       <= 1'b0;
      req_bus.first_load_request  <= 1'b0;
      req_bus.second_load_request <= 1'b0;
      req_bus.third_load_enable   <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table with reset settings
      for (int i = 0; i < DIRECTED_COUNT; i++)
         offer_sample(DIRECTED_TABLE[i].stim, DIRECTED_TABLE[i].has_fixed,
                      DIRECTED_TABLE[i].fixed);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // let the block go idle before touching the registers
         req_bus.valid <= 1'b0;
         while (pending_readings.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);

         case (phase) inside
            0:       kind = SET_MAXIMA;
            1:       kind = SET_ZERO;
            3, 5:    kind = SET_CROSSED;
            7:       kind = SET_DEFAULTS;
            default: kind = SET_TYPICAL;
         endcase
         case (kind)
            SET_MAXIMA: begin
               level = '{32'hFFFF, 32'hFFFF, CODE_MAX, CODE_MAX, CODE_MAX,
                         CODE_MAX, CODE_MAX, CODE_MAX};
            end
            SET_ZERO: begin
               level = '{0, 0, 0, 0, 0, 0, 0, 0};
            end
            SET_DEFAULTS: begin
               level = '{VOLTAGE_GAIN_RST, CURRENT_GAIN_RST, OVERVOLT_TRIP_RST,
                         OVERVOLT_CLEAR_RST, UNDERVOLT_LEVEL_RST, OVERCURRENT_RST,
                         THIRD_ON_RST, THIRD_OFF_RST};
            end
            SET_TYPICAL: begin
               level[CSR_VOLTAGE_GAIN]    = $urandom_range(19000, 13000);
               level[CSR_CURRENT_GAIN]    = $urandom_range(1700, 900);
               level[CSR_OVERVOLT_TRIP]   = $urandom_range(260, 220);
               level[CSR_OVERVOLT_CLEAR]  = level[CSR_OVERVOLT_TRIP] - $urandom_range(6, 0);
               level[CSR_UNDERVOLT_LEVEL] = level[CSR_OVERVOLT_CLEAR] - $urandom_range(20, 5);
               level[CSR_OVERCURRENT]     = $urandom_range(20, 10);
               level[CSR_THIRD_ON]        = $urandom_range(9, 3);
               level[CSR_THIRD_OFF]       = level[CSR_THIRD_ON] + $urandom_range(6, 2);
            end
            default: begin
               // thresholds in any order, gains anywhere
               foreach (level[i]) level[i] = (i < 2) ? $urandom_range(65535, 0)
                                                     : $urandom_range(CODE_MAX, 0);
            end
         endcase

         // all eight registers, then one write to an unused index
         for (int w = 0; w <= 8; w++) begin
            if (w < 8) begin
               wr_index = csr_index_type'(w);
               wr_data  = CSR_DATA_W'(level[w]);
               // junk above a level register's width must be dropped
               if (w >= 2) wr_data[CSR_DATA_W-1:LEVEL_W] = ($urandom_range(1, 0) == 1)
                                 ? (CSR_DATA_W-LEVEL_W)'($urandom >> 8) : '0;
            end else begin
               wr_index = CSR_IDX_W'($urandom_range((1 << CSR_IDX_W) - 1,
                                                    CSR_THIRD_OFF + 1));
               wr_data  = CSR_DATA_W'($urandom);
            end
            csr_wr_en   <= 1'b1;
            csr_index   <= wr_index;
            csr_wr_data <= wr_data;
            @(posedge clock);
            case (wr_index)
               CSR_VOLTAGE_GAIN:    voltage_gain_q  = wr_data;
               CSR_CURRENT_GAIN:    current_gain_q  = wr_data;
               CSR_OVERVOLT_TRIP:   trip_lvl        = wr_data[LEVEL_W-1:0];
               CSR_OVERVOLT_CLEAR:  clear_lvl       = wr_data[LEVEL_W-1:0];
               CSR_UNDERVOLT_LEVEL: under_lvl       = wr_data[LEVEL_W-1:0];
               CSR_OVERCURRENT:     overcurrent_lvl = wr_data[LEVEL_W-1:0];
               CSR_THIRD_ON:        third_on_lvl    = wr_data[LEVEL_W-1:0];
               CSR_THIRD_OFF:       third_off_lvl   = wr_data[LEVEL_W-1:0];
               default: ;
            endcase
         end
         csr_wr_en <= 1'b0;
         settings_used++;

         // idle pattern: sender light/receiver heavy, then swapped, then none
         if (phase < 4) begin
            sender_idle_pct   = 22;
            receiver_idle_pct = 79;
         end else if (phase < 7) begin
            sender_idle_pct   = 79;
            receiver_idle_pct = 22;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         // receiver backs off while samples keep coming
         if (phase == 7) long_hold_armed = 1'b1;

         for (int n = 0; n < SAMPLES_PER_PHASE; n++)
            offer_sample(random_sample(), 1'b0, NO_FIXED_READING);
      end

      req_bus.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d samples over %0d register settings, %0d results compared",
               samples_sent, settings_used, results_checked);
      $display("fault latched in %0d results; off/auto/manual/held modes: %0d/%0d/%0d/%0d",
               faults_seen, mode_seen[MODE_OFF], mode_seen[MODE_AUTO],
               mode_seen[MODE_MANUAL], mode_seen[MODE_HELD]);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
